// ----- sv/osf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osf_pkg
// Shared types and codes of the operand stack with frames.
// ----------------------------------------------------------------------------
package osf_pkg;

    // Default capacity in words
    localparam int DEPTH_DEF = 1024;

    // Fixed field widths
    localparam int FUNC_W   = 4;
    localparam int WORD_W   = 64;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH      = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP       = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK      = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_REVERSE   = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_DISCARD   = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_BEGIN_FR  = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_RESET_FR  = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_SET_FR    = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_GET_FR    = 4'd8;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd3;

    // Input word
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] value;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  new_frame;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [WORD_W-1:0]   data;
        logic [CNT_W-1:0]    depth_now;
        logic [CNT_W-1:0]    frame_now;
        logic [STATUS_W-1:0] status;
    } out_word_t;

endpackage

// ----- sv/operand_stack_with_frames_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// operand_stack_with_frames_core
// Operand stack of 64-bit words with element count and saved frame level.
// ----------------------------------------------------------------------------
// Takes one operation word at a time and returns one result word for each.
// Push, pop, peek, discard and the frame operations go from accept straight to
// the finish state; a reverse of n words adds floor(n/2) swaps, each of which
// goes through the single read port and single write port of the stack
// RAM (read low, read high, write low, write high). A new word is accepted
// while the previous result still waits in the output register. Failing
// operations change nothing and report a status code. The stack RAM has no
// reset; popping or peeking an entry never written returns an undefined word.
// ----------------------------------------------------------------------------
module operand_stack_with_frames_core #(
    parameter int DEPTH = osf_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  osf_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output osf_pkg::out_word_t m_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > osf_pkg::CNT_W) ? CW : osf_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD_LO  = 3'd1;
    localparam logic [2:0] S_RD_HI  = 3'd2;
    localparam logic [2:0] S_WR_LO  = 3'd3;
    localparam logic [2:0] S_WR_HI  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [CW-1:0] frame_reg, frame_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [osf_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic          res_rd_reg, res_rd_next;
    logic [osf_pkg::WORD_W-1:0] lo_data_reg;
    logic          m_valid_reg, m_valid_next;
    osf_pkg::out_word_t m_word_reg;

    // Stack RAM and its ports
    logic [osf_pkg::WORD_W-1:0] mem [DEPTH];
    logic [osf_pkg::WORD_W-1:0] rd_data_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [osf_pkg::WORD_W-1:0] wr_data;

    logic          accept;
    logic          out_load;
    logic [MW-1:0] depth_m, cnt_m, nf_m, depth_minus_cnt;
    logic [CW-1:0] depth_dec;
    logic [AW-1:0] lo_inc, hi_dec;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);

    assign depth_m         = MW'(depth_reg);
    assign cnt_m           = MW'(s_word.count);
    assign nf_m            = MW'(s_word.new_frame);
    assign depth_minus_cnt = depth_m - cnt_m;
    assign depth_dec       = depth_reg - CW'(1);
    assign lo_inc          = lo_reg + AW'(1);
    assign hi_dec          = hi_reg - AW'(1);

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer and state update
    always_comb begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        frame_next      = frame_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        rd_en           = 1'b0;
        rd_addr         = lo_reg;
        wr_en           = 1'b0;
        wr_addr         = lo_reg;
        wr_data         = rd_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next      = S_FINISH;
                    res_status_next = osf_pkg::ST_OK;
                    res_rd_next     = 1'b0;
                    case (s_word.func)
                        osf_pkg::FUNC_PUSH: begin
                            if (depth_reg == DEPTH_C) begin
                                res_status_next = osf_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = depth_reg[AW-1:0];
                                wr_data    = s_word.value;
                                depth_next = depth_reg + CW'(1);
                            end
                        end
                        osf_pkg::FUNC_POP, osf_pkg::FUNC_PEEK: begin
                            if (depth_reg == '0) begin
                                res_status_next = osf_pkg::ST_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = depth_dec[AW-1:0];
                                res_rd_next = 1'b1;
                                if (s_word.func == osf_pkg::FUNC_POP) begin
                                    depth_next = depth_dec;
                                end
                            end
                        end
                        osf_pkg::FUNC_REVERSE: begin
                            if (cnt_m > depth_m) begin
                                res_status_next = osf_pkg::ST_FEW;
                            end else if (cnt_m > MW'(1)) begin
                                lo_next    = depth_minus_cnt[AW-1:0];
                                hi_next    = depth_dec[AW-1:0];
                                state_next = S_RD_LO;
                            end
                        end
                        osf_pkg::FUNC_DISCARD: begin
                            if (cnt_m > depth_m) begin
                                res_status_next = osf_pkg::ST_FEW;
                            end else begin
                                depth_next = depth_minus_cnt[CW-1:0];
                            end
                        end
                        osf_pkg::FUNC_BEGIN_FR: begin
                            frame_next = depth_reg;
                        end
                        osf_pkg::FUNC_RESET_FR: begin
                            depth_next = frame_reg;
                        end
                        osf_pkg::FUNC_SET_FR: begin
                            frame_next = (nf_m > DEPTH_M) ? DEPTH_C : nf_m[CW-1:0];
                        end
                        default: begin
                            // get frame and unused codes change nothing
                        end
                    endcase
                end
            end
            S_RD_LO: begin
                rd_en      = 1'b1;
                rd_addr    = lo_reg;
                state_next = S_RD_HI;
            end
            S_RD_HI: begin
                rd_en      = 1'b1;
                rd_addr    = hi_reg;
                state_next = S_WR_LO;
            end
            S_WR_LO: begin
                // high word lands at the low entry
                wr_en      = 1'b1;
                wr_addr    = lo_reg;
                wr_data    = rd_data_reg;
                state_next = S_WR_HI;
            end
            S_WR_HI: begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = lo_data_reg;
                lo_next = lo_inc;
                hi_next = hi_dec;
                state_next = (lo_inc < hi_dec) ? S_RD_LO : S_FINISH;
            end
            S_FINISH: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            frame_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            frame_reg   <= frame_next;
            m_valid_reg <= m_valid_next;
        end
    end

    function automatic logic [osf_pkg::CNT_W-1:0] frame_m_low(input logic [CW-1:0] f);
        logic [MW-1:0] ext;
        ext = MW'(f);
        return ext[osf_pkg::CNT_W-1:0];
    endfunction

    // Payload registers
    always_ff @(posedge aclk) begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        if (state_reg == S_RD_HI) begin
            lo_data_reg <= rd_data_reg;
        end
        if (out_load) begin
            m_word_reg.data      <= res_rd_reg ? rd_data_reg : '0;
            m_word_reg.depth_now <= depth_m[osf_pkg::CNT_W-1:0];
            m_word_reg.frame_now <= frame_m_low(frame_reg);
            m_word_reg.status    <= res_status_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // Checks
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_C)
        else $error("stack count above capacity");

    a_frame_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_reg <= DEPTH_C)
        else $error("frame level above capacity");

    a_swap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR_LO || state_reg == S_WR_HI) |-> lo_reg < hi_reg)
        else $error("reverse swap with crossed pointers");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_word.func == osf_pkg::FUNC_PUSH && depth_reg != DEPTH_C)
        |=> depth_reg == $past(depth_reg) + CW'(1))
        else $error("push did not grow the stack");

endmodule

// ----- sim/stack_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_checker
// Watches both channels of the operand stack, predicts and compares results.
// ----------------------------------------------------------------------------
// Keeps its own copy of the stack memory, element count and frame level. Each
// accepted operation word is applied to that copy and the predicted result
// word is queued. Each accepted result word is compared field by field with
// the oldest prediction. Mismatches are counted; the first ten are printed.
// ----------------------------------------------------------------------------
module stack_checker #(
    parameter int DEPTH = osf_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  osf_pkg::in_word_t  s_word,
    input  logic               m_valid,
    input  logic               m_ready,
    input  osf_pkg::out_word_t m_word,
    output int                 mismatches,
    output int                 outstanding,
    output int                 checked
);
    import osf_pkg::*;

    localparam int REPORT_MAX = 10;

    logic [WORD_W-1:0] stack_mem [DEPTH];
    int                stk_depth;
    int                frm_level;
    out_word_t         pending_results [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
        stk_depth   = 0;
        frm_level   = 0;
        for (int i = 0; i < DEPTH; i++) begin
            stack_mem[i] = '0;
        end
    end

    // Apply one operation to the shadow stack and return its result word
    function automatic out_word_t apply_stack_op(in_word_t w);
        out_word_t         r;
        int                cnt;
        int                nf;
        int                lo;
        int                hi;
        logic [WORD_W-1:0] tmp;
        r      = '0;
        r.status = ST_OK;
        cnt    = int'(w.count);
        nf     = int'(w.new_frame);
        case (w.func)
            FUNC_PUSH: begin
                if (stk_depth >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_mem[stk_depth] = w.value;
                    stk_depth++;
                end
            end
            FUNC_POP, FUNC_PEEK: begin
                if (stk_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = stack_mem[stk_depth-1];
                    if (w.func == FUNC_POP) begin
                        stk_depth--;
                    end
                end
            end
            FUNC_REVERSE: begin
                if (cnt > stk_depth) begin
                    r.status = ST_FEW;
                end else if (cnt > 1) begin
                    lo = stk_depth - cnt;
                    hi = stk_depth - 1;
                    while (lo < hi) begin
                        tmp           = stack_mem[lo];
                        stack_mem[lo] = stack_mem[hi];
                        stack_mem[hi] = tmp;
                        lo++;
                        hi--;
                    end
                end
            end
            FUNC_DISCARD: begin
                if (cnt > stk_depth) begin
                    r.status = ST_FEW;
                end else begin
                    stk_depth -= cnt;
                end
            end
            FUNC_BEGIN_FR: frm_level = stk_depth;
            FUNC_RESET_FR: stk_depth = frm_level;
            // saturate to capacity
            FUNC_SET_FR:   frm_level = (nf > DEPTH) ? DEPTH : nf;
            default: ;
        endcase
        r.depth_now = CNT_W'(stk_depth);
        r.frame_now = CNT_W'(frm_level);
        return r;
    endfunction

    // Monitor: input side queues predictions, output side compares
    always @(posedge aclk) begin : monitor
        out_word_t exp_w;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_results.push_back(apply_stack_op(s_word));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: result word with nothing pending: data=%h depth=%0d frame=%0d status=%0d",
                                 $realtime, m_word.data, m_word.depth_now,
                                 m_word.frame_now, m_word.status);
                    end
                end else begin
                    exp_w = pending_results.pop_front();
                    checked++;
                    if (m_word.data !== exp_w.data ||
                        m_word.depth_now !== exp_w.depth_now ||
                        m_word.frame_now !== exp_w.frame_now ||
                        m_word.status !== exp_w.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: mismatch on result %0d", $realtime, checked);
                            $display("  expected data=%h depth=%0d frame=%0d status=%0d",
                                     exp_w.data, exp_w.depth_now, exp_w.frame_now,
                                     exp_w.status);
                            $display("  actual   data=%h depth=%0d frame=%0d status=%0d",
                                     m_word.data, m_word.depth_now, m_word.frame_now,
                                     m_word.status);
                        end
                    end
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the operand stack with frames.
// ----------------------------------------------------------------------------
// Drives a directed run over the stack edges (empty, full, saturated frame,
// zero and oversized counts, full-depth reverse), then three random phases
// with different sender and receiver pacing. A shadow of the count, frame and
// written entries keeps pops and peeks away from words never written.
// Checking is done by stack_checker, instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import osf_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int STALL_LIMIT  = 20000;
    localparam int PHASE_ITEMS  = 640;
    localparam int SEG_ITEMS    = 80;
    localparam int RX_HOLD      = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CNT_MAX      = (1 << CNT_W) - 1;
    localparam logic [FUNC_W-1:0] FUNC_MAX = '1;
    localparam int PHASE_FULL_LOAD = 3;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_word_t  s_word  = '0;
    logic      m_ready = 1'b0;
    logic      s_ready;
    logic      m_valid;
    out_word_t m_word;

    int mismatches;
    int outstanding;
    int checked;

    // pacing
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int pace_phase    = 0;
    int rx_seen_phase = 0;
    int rx_hold_left  = 0;

    int words_sent  = 0;
    int idle_cycles = 0;

    // stimulus-side view of the stack, used to shape legal traffic
    int sh_depth = 0;
    int sh_frame = 0;
    bit sh_written [DEPTH];

    always #4 aclk = ~aclk;

    operand_stack_with_frames_core #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_word (s_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word (m_word)
    );

    stack_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word),
        .mismatches (mismatches),
        .outstanding(outstanding),
        .checked    (checked)
    );

    // Receiver: random stalls, plus one long hold-off entering the last phase
    always @(posedge aclk) begin
        if (pace_phase != rx_seen_phase) begin
            rx_seen_phase = pace_phase;
            if (pace_phase == PHASE_FULL_LOAD) begin
                rx_hold_left = RX_HOLD;
            end
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic in_word_t op_word(logic [FUNC_W-1:0] f,
                                         logic [WORD_W-1:0] v = '0,
                                         int cnt = 0, int nf = 0);
        in_word_t w;
        w.func      = f;
        w.value     = v;
        w.count     = CNT_W'(cnt);
        w.new_frame = CNT_W'(nf);
        return w;
    endfunction

    // Follow count, frame and written entries for an accepted word
    task automatic track_word(input in_word_t w);
        int cnt;
        int nf;
        int lo;
        int hi;
        bit tmp;
        cnt = int'(w.count);
        nf  = int'(w.new_frame);
        case (w.func)
            FUNC_PUSH: begin
                if (sh_depth < DEPTH) begin
                    sh_written[sh_depth] = 1'b1;
                    sh_depth++;
                end
            end
            FUNC_POP: if (sh_depth > 0) sh_depth--;
            FUNC_REVERSE: begin
                if (cnt <= sh_depth && cnt > 1) begin
                    lo = sh_depth - cnt;
                    hi = sh_depth - 1;
                    while (lo < hi) begin
                        tmp            = sh_written[lo];
                        sh_written[lo] = sh_written[hi];
                        sh_written[hi] = tmp;
                        lo++;
                        hi--;
                    end
                end
            end
            FUNC_DISCARD:  if (cnt <= sh_depth) sh_depth -= cnt;
            FUNC_BEGIN_FR: sh_frame = sh_depth;
            FUNC_RESET_FR: sh_depth = sh_frame;
            FUNC_SET_FR:   sh_frame = (nf > DEPTH) ? DEPTH : nf;
            default: ;
        endcase
    endtask

    // Offer one word; called at a rising edge, returns at the accepting edge
    task automatic send_word(input in_word_t w);
        // sender idles cycle by cycle at the phase's idle rate
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        // ready is stable mid-cycle; accept happens at the following edge
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        track_word(w);
        words_sent++;
    endtask

    // Sender pause: drop valid and wait for every result to come back
    task automatic drain_results();
        s_valid <= 1'b0;
        // let the checker book the word accepted at this edge first
        @(posedge aclk);
        wait (outstanding == 0);
        @(posedge aclk);
    endtask

    function automatic in_word_t random_word(int push_pct);
        in_word_t w;
        int       r;
        int       cnt_top;
        cnt_top = (sh_depth + 2 > CNT_MAX) ? CNT_MAX : sh_depth + 2;
        w.value = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: w.count = CNT_W'($urandom_range(0, 8));
            6, 7:             w.count = CNT_W'($urandom_range(0, cnt_top));
            8:                w.count = CNT_W'(sh_depth);
            default:          w.count = CNT_W'($urandom_range(0, CNT_MAX));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            w.new_frame = CNT_W'($urandom_range(0, CNT_MAX));
        end else begin
            w.new_frame = CNT_W'($urandom_range(0, sh_depth));
        end
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            w.func = FUNC_PUSH;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 30)      w.func = FUNC_POP;
            else if (r < 40) w.func = FUNC_PEEK;
            else if (r < 55) w.func = FUNC_REVERSE;
            else if (r < 65) w.func = FUNC_DISCARD;
            else if (r < 72) w.func = FUNC_BEGIN_FR;
            else if (r < 79) w.func = FUNC_RESET_FR;
            else if (r < 86) w.func = FUNC_SET_FR;
            else if (r < 93) w.func = FUNC_GET_FR;
            else             w.func = FUNC_W'($urandom_range(FUNC_GET_FR + 1, FUNC_MAX));
        end
        // top entry exposed by a frame reset but never written: push instead
        if ((w.func == FUNC_POP || w.func == FUNC_PEEK) && sh_depth > 0 &&
            !sh_written[sh_depth-1]) begin
            w.func = FUNC_PUSH;
        end
        return w;
    endfunction

    // One random phase: segments with changing push bias, then a drain
    task automatic run_phase(input int tx_pct, input int rx_pct, input int phase);
        int push_pct;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        pace_phase  = phase;
        push_pct    = 50;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % SEG_ITEMS == 0) begin
                case ($urandom_range(0, 4))
                    0:       push_pct = 20;
                    1:       push_pct = 35;
                    2:       push_pct = 50;
                    3:       push_pct = 70;
                    default: push_pct = 90;
                endcase
            end
            send_word(random_word(push_pct));
        end
        drain_results();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 23;
        rx_idle_pct = 60;
        pace_phase  = 1;

        // empty stack and count edges
        send_word(op_word(FUNC_POP));
        send_word(op_word(FUNC_PEEK));
        send_word(op_word(FUNC_REVERSE, '0, 0));
        send_word(op_word(FUNC_DISCARD, '0, 0));
        send_word(op_word(FUNC_REVERSE, '0, 1));
        send_word(op_word(FUNC_DISCARD, '0, CNT_MAX));
        // extreme data words, reverse of whole and partial stack
        send_word(op_word(FUNC_PUSH, '0));
        send_word(op_word(FUNC_PUSH, '1));
        send_word(op_word(FUNC_PUSH, 64'hA5A5_A5A5_A5A5_A5A5));
        send_word(op_word(FUNC_PUSH, 64'h5A5A_5A5A_5A5A_5A5A));
        send_word(op_word(FUNC_PEEK));
        send_word(op_word(FUNC_REVERSE, '0, 4));
        send_word(op_word(FUNC_REVERSE, '0, 3));
        // frame save, shrink, then reset to frame raising the count
        send_word(op_word(FUNC_BEGIN_FR));
        send_word(op_word(FUNC_PUSH, 64'h1));
        send_word(op_word(FUNC_DISCARD, '0, 2));
        send_word(op_word(FUNC_GET_FR));
        send_word(op_word(FUNC_RESET_FR));
        send_word(op_word(FUNC_POP));
        // saturated frame, full stack, full-depth reverse
        send_word(op_word(FUNC_SET_FR, '0, 0, CNT_MAX));
        send_word(op_word(FUNC_RESET_FR));
        send_word(op_word(FUNC_PUSH, 64'h0123_4567_89AB_CDEF));
        send_word(op_word(FUNC_REVERSE, '0, DEPTH));
        send_word(op_word(FUNC_PEEK));
        send_word(op_word(FUNC_DISCARD, '0, DEPTH));
        send_word(op_word(FUNC_MAX, '1, CNT_MAX, CNT_MAX));
        send_word(op_word(FUNC_SET_FR, '0, 0, 0));
        drain_results();

        run_phase(23, 60, 1);
        run_phase(60, 23, 2);
        run_phase(0, 0, PHASE_FULL_LOAD);

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d operation words: directed stack edges, then three pacing phases",
                 words_sent);
        $display("with a long output stall; %0d result words checked, %0d mismatches",
                 checked, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/osf_pkg.sv
sv/operand_stack_with_frames_core.sv
sim/stack_checker.sv
sim/tb_top.sv
